// File: rtl/fhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// fhc_pkg: shared types and constants for the float/half converter.
// No dependencies.
package fhc_pkg;

	typedef enum logic {
		OP_S2H = 1'b0,
		OP_H2S = 1'b1
	} op_t;

	localparam logic [7:0]  SGL_EXP_MAX  = 8'hFF;
	localparam logic [4:0]  HLF_EXP_MAX  = 5'h1F;
	localparam logic [7:0]  EXP_REBIAS   = 8'd112;
	// single exponents at or above this overflow half
	localparam logic [7:0]  SGL_OVF_EXP  = 8'd143;
	// single exponents at or below this give a half subnormal
	localparam logic [7:0]  SGL_SUB_EXP  = 8'd112;
	// single exponents below this flush to zero
	localparam logic [7:0]  SGL_FLUSH_EXP = 8'd102;
	// subnormal shift is SUB_BASE - exponent
	localparam logic [7:0]  SUB_BASE     = 8'd113;
	// half subnormal renormalizes to exponent field LZ_BASE + msb position
	localparam logic [7:0]  LZ_BASE      = 8'd103;

	localparam logic [15:0] HLF_INF      = 16'h7C00;
	localparam logic [15:0] HLF_QNAN_BIT = 16'h0200;
	localparam logic [31:0] SGL_INF      = 32'h7F80_0000;
	localparam logic [31:0] SGL_QNAN_BIT = 32'h0040_0000;

	// position of the most significant set bit of a nonzero 10-bit mantissa
	function automatic logic [3:0] msb_pos(input logic [9:0] m);
		logic [3:0] pos;
		pos = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) begin
				pos = 4'(i);
			end
		end
		return pos;
	endfunction

endpackage
`default_nettype wire

// File: rtl/fhc_s2h.sv
`timescale 1ns / 1ps
`default_nettype none
// fhc_s2h: combinational single-to-half conversion, truncating.
// Uses fhc_pkg.
module fhc_s2h (
	input  wire logic [31:0] operand,
	output logic      [15:0] result
);

	logic        sign;
	logic [7:0]  exp;
	logic [22:0] mant;
	logic [7:0]  sub_shift;
	logic [10:0] sub_mant;
	logic [7:0]  hexp;

	assign sign = operand[31];
	assign exp  = operand[30:23];
	assign mant = operand[22:0];

	// shift of 1..11 applied to the 11-bit significand, same as shifting 24 bits by 14..24
	assign sub_shift = fhc_pkg::SUB_BASE - exp;
	assign sub_mant  = {1'b1, mant[22:13]} >> sub_shift[3:0];
	assign hexp      = exp - fhc_pkg::EXP_REBIAS;

	always_comb begin
		if (exp == fhc_pkg::SGL_EXP_MAX) begin
			result = {sign, 15'd0} | fhc_pkg::HLF_INF
				| ((mant != 23'd0) ? fhc_pkg::HLF_QNAN_BIT : 16'd0);
		end else if (exp == 8'd0) begin
			result = {sign, 15'd0};
		end else if (exp >= fhc_pkg::SGL_OVF_EXP) begin
			result = {sign, 15'd0} | fhc_pkg::HLF_INF;
		end else if (exp < fhc_pkg::SGL_FLUSH_EXP) begin
			result = {sign, 15'd0};
		end else if (exp <= fhc_pkg::SGL_SUB_EXP) begin
			result = {sign, 5'd0, sub_mant[9:0]};
		end else begin
			result = {sign, hexp[4:0], mant[22:13]};
		end
	end

endmodule
`default_nettype wire

// File: rtl/fhc_h2s.sv
`timescale 1ns / 1ps
`default_nettype none
// fhc_h2s: combinational half-to-single conversion, exact.
// Uses fhc_pkg (msb_pos, constants).
module fhc_h2s (
	input  wire logic [15:0] operand,
	output logic      [31:0] result
);

	logic        sign;
	logic [4:0]  exp;
	logic [9:0]  mant;
	logic [3:0]  pos;
	logic [3:0]  norm_shift;
	logic [19:0] norm_mant;
	logic [7:0]  sub_exp;

	assign sign = operand[15];
	assign exp  = operand[14:10];
	assign mant = operand[9:0];

	// subnormal: move the leading one to the hidden position
	assign pos        = fhc_pkg::msb_pos(mant);
	assign norm_shift = 4'd10 - pos;
	assign norm_mant  = {10'd0, mant} << norm_shift;
	assign sub_exp    = fhc_pkg::LZ_BASE + {4'd0, pos};

	always_comb begin
		if (exp == fhc_pkg::HLF_EXP_MAX) begin
			result = {sign, 31'd0} | fhc_pkg::SGL_INF
				| ((mant != 10'd0) ? fhc_pkg::SGL_QNAN_BIT : 32'd0);
		end else if (exp == 5'd0) begin
			if (mant == 10'd0) begin
				result = {sign, 31'd0};
			end else begin
				result = {sign, sub_exp, norm_mant[9:0], 13'd0};
			end
		end else begin
			result = {sign, {3'd0, exp} + fhc_pkg::EXP_REBIAS, mant, 13'd0};
		end
	end

endmodule
`default_nettype wire

// File: rtl/float_half_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// float_half_converter: IEEE single <-> half bit pattern converter. Each request
// transfer carries req_type (0: single to half, 1: half to single) and a 32-bit
// operand; each response transfer carries one 32-bit result, with half results in
// bits 15..0 and zeros above. Single to half truncates toward zero, flushes values
// below the half subnormal range to signed zero, saturates overflow to infinity and
// turns NaN into a quiet NaN with the sign kept. Half to single is exact. The
// operand is captured in an input register, converted by a short combinational
// path (exponent compare, a barrel shift of at most 11 bits, a 10-bit leading-one
// search) and captured in the result register, which drives rsp_valid and
// result_bits. Throughput is one transfer per cycle while rsp_stall is low; both
// registers advance whenever the stage ahead is empty or being drained, so
// req_stall rises only when both stages hold data and rsp_stall is high. Uses
// fhc_pkg, fhc_s2h and fhc_h2s.
module float_half_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        req_type,
	input  wire logic [31:0] operand_bits,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic      [31:0] result_bits
);

	// stage 1: captured request
	logic             valid_s1;
	fhc_pkg::op_t     op_s1;
	logic [31:0]      operand_s1;
	// stage 2: result register
	logic             valid_s2;
	fhc_pkg::op_t     op_s2;
	logic [31:0]      result_s2;

	logic             load_s2;
	logic             load_s1;
	logic [15:0]      half_res;
	logic [31:0]      single_res;
	logic [31:0]      conv_res;

	// stage 2 takes data when empty or its content leaves this cycle
	assign load_s2   = !valid_s2 || !rsp_stall;
	assign load_s1   = !valid_s1 || load_s2;
	assign req_stall = !load_s1;

	fhc_s2h u_s2h (
		.operand (operand_s1),
		.result  (half_res)
	);

	fhc_h2s u_h2s (
		.operand (operand_s1[15:0]),
		.result  (single_res)
	);

	always_comb begin
		unique case (op_s1)
			fhc_pkg::OP_S2H: conv_res = {16'd0, half_res};
			fhc_pkg::OP_H2S: conv_res = single_res;
			default:         conv_res = {16'd0, half_res};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= req_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (load_s1 && req_valid) begin
			op_s1      <= fhc_pkg::op_t'(req_type);
			operand_s1 <= operand_bits;
		end
		if (load_s2 && valid_s1) begin
			op_s2     <= op_s1;
			result_s2 <= conv_res;
		end
	end

	assign rsp_valid   = valid_s2;
	assign result_bits = result_s2;

	// backpressure only with both stages full and the output blocked
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && rsp_stall))
		else $error("req_stall raised with room in the pipeline");

	// a captured item reaches the result register when it is free
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("stage 1 item did not advance");

	// half results keep the upper half clear
	a_half_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && op_s2 == fhc_pkg::OP_S2H) |-> (result_s2[31:16] == 16'd0))
		else $error("half result with upper bits set");

endmodule
`default_nettype wire

// File: tb/float_half_converter_tb.sv
`timescale 1ns / 1ps
// float_half_converter_tb: self-checking bench for the single/half converter.
// Needs fhc_pkg and the float_half_converter RTL; reads no files.
module float_half_converter_tb;

	localparam int CLK_PERIOD   = 12;
	localparam int NUM_DIRECTED = 26;
	localparam int NUM_RANDOM   = 1525;

	// One directed row. Where known is set, the expected pattern is typed in.
	// Otherwise the predictor supplies it.
	typedef struct {
		fhc_pkg::op_t kind;
		logic [31:0]  operand;
		bit           known;
		logic [31:0]  result;
	} vector_t;

	// One accepted request and the pattern it must produce.
	typedef struct {
		fhc_pkg::op_t kind;
		logic [31:0]  operand;
		logic [31:0]  result;
	} conversion_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic        req_type;
	logic [31:0] operand_bits;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [31:0] result_bits;

	conversion_t pending_results[$];
	conversion_t oldest;
	int          failures = 0;
	int          checked  = 0;
	int          sent_s2h = 0;
	int          sent_h2s = 0;
	bit          steady   = 1'b0;	// when set, neither side inserts gaps

	vector_t directed_vectors [NUM_DIRECTED] = '{
		// single to half: zeros, infinities, NaNs
		'{fhc_pkg::OP_S2H, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{fhc_pkg::OP_S2H, 32'h8000_0000, 1'b1, 32'h0000_8000},
		'{fhc_pkg::OP_S2H, 32'h7F80_0000, 1'b1, 32'h0000_7C00},
		'{fhc_pkg::OP_S2H, 32'hFF80_0000, 1'b1, 32'h0000_FC00},
		'{fhc_pkg::OP_S2H, 32'h7FC0_0001, 1'b1, 32'h0000_7E00},
		'{fhc_pkg::OP_S2H, 32'hFF80_0001, 1'b1, 32'h0000_FE00},
		// normal range, largest half, first overflowing exponent, largest single
		'{fhc_pkg::OP_S2H, 32'h3F80_0000, 1'b1, 32'h0000_3C00},
		'{fhc_pkg::OP_S2H, 32'h477F_E000, 1'b1, 32'h0000_7BFF},
		'{fhc_pkg::OP_S2H, 32'h4780_0000, 1'b1, 32'h0000_7C00},
		'{fhc_pkg::OP_S2H, 32'h7F7F_FFFF, 1'b1, 32'h0000_7C00},
		// smallest half normal, half subnormals down to the smallest one
		'{fhc_pkg::OP_S2H, 32'h3880_0000, 1'b1, 32'h0000_0400},
		'{fhc_pkg::OP_S2H, 32'h3800_0000, 1'b1, 32'h0000_0200},
		'{fhc_pkg::OP_S2H, 32'h3380_0000, 1'b1, 32'h0000_0001},
		'{fhc_pkg::OP_S2H, 32'hB37F_FFFF, 1'b0, 32'h0},
		// deep underflow and single subnormal flush to signed zero
		'{fhc_pkg::OP_S2H, 32'hB2FF_FFFF, 1'b1, 32'h0000_8000},
		'{fhc_pkg::OP_S2H, 32'h807F_FFFF, 1'b1, 32'h0000_8000},
		// half to single: zeros, infinities, NaNs, normals, upper bits ignored
		'{fhc_pkg::OP_H2S, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{fhc_pkg::OP_H2S, 32'h0000_8000, 1'b1, 32'h8000_0000},
		'{fhc_pkg::OP_H2S, 32'h0000_7C00, 1'b1, 32'h7F80_0000},
		'{fhc_pkg::OP_H2S, 32'h0000_FC00, 1'b1, 32'hFF80_0000},
		'{fhc_pkg::OP_H2S, 32'h0000_7C01, 1'b1, 32'h7FC0_0000},
		'{fhc_pkg::OP_H2S, 32'hFFFF_FFFF, 1'b1, 32'hFFC0_0000},
		'{fhc_pkg::OP_H2S, 32'hFFFF_3C00, 1'b1, 32'h3F80_0000},
		'{fhc_pkg::OP_H2S, 32'h0000_7BFF, 1'b1, 32'h477F_E000},
		// half subnormals need renormalizing
		'{fhc_pkg::OP_H2S, 32'h0000_0001, 1'b0, 32'h0},
		'{fhc_pkg::OP_H2S, 32'h0000_83FF, 1'b0, 32'h0}
	};

	float_half_converter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.operand_bits (operand_bits),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.result_bits  (result_bits)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Expected pattern for one conversion.
	// Single to half truncates. Half to single is exact and
	// renormalizes subnormals.
	function automatic logic [31:0] convert_pattern(fhc_pkg::op_t kind,
			logic [31:0] operand);
		logic        sgn;
		logic [7:0]  s_exp;
		logic [22:0] s_man;
		logic [23:0] sig;
		logic [15:0] half;
		logic [4:0]  h_exp;
		logic [9:0]  h_man;
		logic [10:0] norm;
		int          unbiased;
		int          lead;
		if (kind == fhc_pkg::OP_S2H) begin
			sgn      = operand[31];
			s_exp    = operand[30:23];
			s_man    = operand[22:0];
			unbiased = int'(s_exp) - 112;	// half exponent field, signed
			if (s_exp == 8'hFF) begin
				half = {sgn, 5'h1F, s_man != 23'd0, 9'd0};
			end else if (s_exp == 8'd0) begin
				half = {sgn, 15'd0};
			end else if (unbiased >= 31) begin
				half = {sgn, 5'h1F, 10'd0};
			end else if (unbiased < -10) begin
				half = {sgn, 15'd0};
			end else if (unbiased <= 0) begin
				// hidden one restored, then truncating shift into the subnormal field
				sig  = {1'b1, s_man};
				half = {sgn, 5'd0, 10'(sig >> (14 - unbiased))};
			end else begin
				half = {sgn, 5'(unbiased), s_man[22:13]};
			end
			return {16'd0, half};
		end
		sgn   = operand[15];
		h_exp = operand[14:10];
		h_man = operand[9:0];
		if (h_exp == 5'h1F) begin
			return {sgn, 8'hFF, h_man != 10'd0, 22'd0};
		end
		if (h_exp == 5'd0) begin
			if (h_man == 10'd0) begin
				return {sgn, 31'd0};
			end
			norm = {1'b0, h_man};
			lead = 0;
			while (!norm[10]) begin
				norm = norm << 1;
				lead++;
			end
			return {sgn, 8'(113 - lead), norm[9:0], 13'd0};
		end
		return {sgn, 8'(h_exp) + 8'd112, h_man, 13'd0};
	endfunction

	// Idle length: mostly none or short, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Single operand biased toward the band from flush through overflow,
	// with zero and all-ones exponents mixed in.
	function automatic logic [31:0] pick_single();
		logic [7:0]  ex;
		logic [22:0] man;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			ex = 8'($urandom_range(98, 146));
		end else if (r < 63) begin
			ex = 8'h00;
		end else if (r < 71) begin
			ex = 8'hFF;
		end else begin
			ex = 8'($urandom);
		end
		r = $urandom_range(0, 9);
		man = (r == 0) ? 23'd0 : (r == 1) ? '1 : 23'($urandom);
		return {1'($urandom), ex, man};
	endfunction

	// Half operand in the low 16 bits. The upper half is random noise.
	function automatic logic [31:0] pick_half();
		logic [4:0]  ex;
		logic [9:0]  man;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			ex = 5'h00;
		end else if (r < 24) begin
			ex = 5'h1F;
		end else begin
			ex = 5'($urandom);
		end
		r = $urandom_range(0, 9);
		man = (r == 0) ? 10'd0 : (r == 1) ? '1 : 10'($urandom);
		return {16'($urandom), 1'($urandom), ex, man};
	endfunction

	// Drive one request and hold it until the transfer happens. Then log the
	// expected result. Payload is scrambled during gaps; valid is low then.
	task automatic send_transfer(fhc_pkg::op_t kind, logic [31:0] operand, bit known,
			logic [31:0] typed_result);
		int unsigned gap;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			req_valid    <= 1'b0;
			operand_bits <= $urandom;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		req_type     <= kind;
		operand_bits <= operand;
		do @(posedge clk); while (req_stall);
		pending_results.push_back('{kind, operand,
			known ? typed_result : convert_pattern(kind, operand)});
		if (kind == fhc_pkg::OP_S2H) begin
			sent_s2h++;
		end else begin
			sent_h2s++;
		end
	endtask

	// Response side stalls in random bursts. It runs free during steady stretches.
	initial begin
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			repeat (steady ? 0 : idle_len()) begin
				rsp_stall <= 1'b1;
				@(posedge clk);
			end
			repeat ($urandom_range(1, 6)) begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Each result transfer is checked against the oldest expected result.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("result_bits: unexpected transfer, actual %h", result_bits);
				failures++;
			end else begin
				oldest = pending_results.pop_front();
				checked++;
				if (result_bits !== oldest.result) begin
					$error("result_bits mismatch (%s operand %h): expected %h, actual %h",
						oldest.kind.name(), oldest.operand, oldest.result, result_bits);
					failures++;
				end
			end
		end
	end

	initial begin
		fhc_pkg::op_t kind;
		logic [31:0]  operand;
		arst_n       <= 1'b0;
		req_valid    <= 1'b0;
		req_type     <= fhc_pkg::OP_S2H;
		operand_bits <= 32'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: special values and range boundaries for both directions.
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_transfer(directed_vectors[i].kind, directed_vectors[i].operand,
				directed_vectors[i].known, directed_vectors[i].result);
		end

		// Random part. Every fifth stretch runs back to back with no gaps.
		// A few operands are fully random noise.
		for (int i = 0; i < NUM_RANDOM; i++) begin
			steady = ((i / 150) % 5) == 4;
			kind   = fhc_pkg::op_t'($urandom_range(0, 1));
			if ($urandom_range(0, 19) == 0) begin
				operand = $urandom;
			end else begin
				operand = (kind == fhc_pkg::OP_S2H) ? pick_single() : pick_half();
			end
			send_transfer(kind, operand, 1'b0, 32'd0);
		end
		steady = 1'b0;
		req_valid <= 1'b0;

		// Drain the pipeline. Then keep clocking to catch stray results.
		for (int w = 0; w < 5000 && pending_results.size() != 0; w++) begin
			@(posedge clk);
		end
		if (pending_results.size() != 0) begin
			$error("result_bits: %0d expected results never arrived",
				pending_results.size());
			failures++;
		end
		repeat (8) @(posedge clk);

		$display("Converted %0d single-to-half and %0d half-to-single operands,",
			sent_s2h, sent_h2s);
		$display("%0d results checked, random stalls on both sides", checked);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog: the run is far shorter than this even with the longest stalls.
	initial begin
		#(CLK_PERIOD * 1000000);
		$display("Test completed with failures");
		$finish;
	end

endmodule
